// ===== rtl/swms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swms_pkg: constants for the window statistics core
// Sizes of the sample store, data widths and the window reset value.
// ----------------------------------------------------------------------------
package swms_pkg;
  localparam int MaxWindow   = 128;
  localparam int NumChannels = 2;
  localparam int PtrW        = $clog2(MaxWindow);
  localparam int ChW         = 1;
  localparam int AddrW       = ChW + PtrW;
  localparam int Depth       = NumChannels * MaxWindow;
  localparam int CntW        = 8;
  localparam int SampW       = 80;
  localparam int InDataW     = 80;
  localparam int OutDataW    = 168;
  localparam logic [CntW-1:0] WinReset = 8'd10;
endpackage

// ===== rtl/swms_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swms_ram: generic single-port RAM
// One write plus one registered read per cycle; a read at the written address returns the old word.
// ----------------------------------------------------------------------------
module swms_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write and read at one address; the read returns the old word
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/sliding_window_mean_stddev_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_mean_stddev_core: windowed mean and standard deviation
// Per channel sample ring; sums and squared deviations per coordinate, one divider for mean and deviation.
// ----------------------------------------------------------------------------
// A request writes its sample to the store; then each coordinate in turn takes
// two RAM passes over the window of n samples, two restoring divides, an 8-step
// multiply by n and a 40-step square root. in_tready is low until the result is
// taken.
// Reset (rst_n low, synchronous) clears pointers and fill counts and loads the
// window register with 10; the sample store is not cleared.
module sliding_window_mean_stddev_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [swms_pkg::InDataW-1:0]  in_tdata,   // pos_x, pos_y, heading
  input  logic                          in_tuser,   // channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [swms_pkg::OutDataW-1:0] out_tdata,  // mean_x, mean_y, mean_heading,
                                                    // dev_x, dev_y, dev_heading,
                                                    // samples
  output logic                          out_tuser,  // out_channel
  input  logic                          cfg_we,
  input  logic [7:0]                    cfg_wdata
);
  import swms_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SUM   = 11'b00000000010,
    S_DIV   = 11'b00000000100,
    S_DEV   = 11'b00000001000,
    S_MULN  = 11'b00000010000,
    S_SQRT  = 11'b00000100000,
    S_DIVD  = 11'b00001000000,
    S_NEXT  = 11'b00010000000,
    S_OUT   = 11'b00100000000,
    S_WR    = 11'b01000000000,
    S_MSQ   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CntW-1:0] win_r;
  logic [PtrW-1:0] wp_r [NumChannels];
  logic [CntW-1:0] fill_r [NumChannels];
  logic [ChW-1:0]  ch_r;
  logic [PtrW-1:0] base_r;       // newest slot
  logic [CntW-1:0] n_r;
  logic [CntW-1:0] k_r;          // samples issued
  logic [CntW-1:0] got_r;        // samples received
  logic [1:0]      crd_r;        // coordinate: 0 x, 1 y, 2 heading
  logic            rd_pend_r;
  logic [SampW-1:0] in_hold_r;

  // datapath registers
  logic signed [39:0] sum_r;
  logic signed [32:0] mean_r;
  logic [39:0]        rem_r;     // divider remainder, then its square
  logic [39:0]        quo_r;
  logic               neg_r;
  logic [6:0]         step_r;
  logic [71:0]        acc_r;     // sum of squared deviations
  logic [79:0]        a_r;       // radicand
  logic [39:0]        root_r;
  logic [79:0]        rsq_r;     // root_r squared
  logic [63:0]        sq_r;      // pipelined product
  logic [31:0]        mean_o_r [3];
  logic [31:0]        dev_o_r [3];

  // RAM
  logic [AddrW-1:0] ram_addr;
  logic             ram_we;
  logic [SampW-1:0] ram_rdata;

  swms_ram #(.Width(SampW), .Depth(Depth)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_hold_r),
    .rdata (ram_rdata)
  );

  logic [PtrW-1:0] rd_slot;
  assign rd_slot = base_r - k_r[PtrW-1:0];
  assign ram_we  = (state_r == S_WR);
  assign ram_addr = ram_we ? {ch_r, base_r} : {ch_r, rd_slot};

  // select coordinate from the read word, sign-extended
  logic signed [32:0] samp;
  always_comb begin
    unique case (crd_r)
      2'd0:    samp = {ram_rdata[31], ram_rdata[31:0]};
      2'd1:    samp = {ram_rdata[63], ram_rdata[63:32]};
      default: samp = {{17{ram_rdata[79]}}, ram_rdata[79:64]};
    endcase
  end

  logic issuing;
  assign issuing = (state_r == S_SUM || state_r == S_DEV) && (k_r < n_r);

  // deviation unit: absolute deviation and square
  logic signed [33:0] dif;
  logic [31:0] adif;
  assign dif  = {samp[32], samp} - {mean_r[32], mean_r};
  assign adif = dif[33] ? 32'(-dif) : dif[31:0];

  // divider step: restoring, one quotient bit a cycle
  logic [40:0] dtry;
  assign dtry = {rem_r, quo_r[39]} - {33'd0, n_r};

  // multiply by n: shift and add, most significant bit of n first
  logic [79:0] mul_nx;
  assign mul_nx = {a_r[78:0], 1'b0} + (n_r[step_r[2:0]] ? 80'(acc_r) : 80'd0);

  // square root trial
  logic [39:0] cand;
  logic [79:0] csq;
  logic [39:0] root_nx;
  assign cand = root_r | (40'd1 << step_r[5:0]);
  assign csq  = rsq_r + ({40'd0, root_r} << (step_r[5:0] + 6'd1))
              + (80'd1 << {step_r[5:0], 1'b0});
  assign root_nx = (csq <= a_r) ? cand : root_r;

  logic [CntW-1:0] w_eff;
  always_comb begin
    priority if (win_r == '0) w_eff = 8'd1;
    else if (win_r > 8'(MaxWindow)) w_eff = 8'(MaxWindow);
    else w_eff = win_r;
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tuser = ch_r;
  assign out_tdata = {n_r, dev_o_r[2][15:0], dev_o_r[1], dev_o_r[0],
                      mean_o_r[2][15:0], mean_o_r[1], mean_o_r[0]};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_WR;
      S_WR:   state_nxt = S_SUM;
      S_SUM:  if (got_r == n_r) state_nxt = S_DIV;
      S_DIV:  if (step_r == 7'd40) state_nxt = S_DEV;
      S_DEV:  if (got_r == n_r && !rd_pend_r) state_nxt = S_MSQ;
      S_MSQ:  state_nxt = S_MULN;
      S_MULN: if (step_r == 7'd0) state_nxt = S_SQRT;
      S_SQRT: if (step_r == 7'd0) state_nxt = S_DIVD;
      S_DIVD: if (step_r == 7'd40) state_nxt = S_NEXT;
      S_NEXT: state_nxt = (crd_r == 2'd2) ? S_OUT : S_SUM;
      S_OUT:  if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      win_r   <= WinReset;
      for (int i = 0; i < NumChannels; i++) begin
        wp_r[i]   <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) win_r <= cfg_wdata;
      if (state_r == S_IDLE && in_tvalid) begin
        wp_r[in_tuser] <= wp_r[in_tuser] + 1'b1;
        fill_r[in_tuser] <= (fill_r[in_tuser] + 1'b1 > w_eff) ? w_eff
                            : fill_r[in_tuser] + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rd_pend_r <= issuing;
    unique case (state_r)
      S_IDLE: begin
        in_hold_r <= in_tdata;
        ch_r   <= in_tuser;
        base_r <= wp_r[in_tuser];
        n_r    <= (fill_r[in_tuser] + 1'b1 > w_eff) ? w_eff
                  : fill_r[in_tuser] + 1'b1;
        crd_r  <= 2'd0;
        k_r <= '0; got_r <= '0; sum_r <= '0;
      end
      S_WR: ;
      S_SUM: begin
        if (issuing) k_r <= k_r + 1'b1;
        if (rd_pend_r) begin
          sum_r <= sum_r + 40'(samp);
          got_r <= got_r + 1'b1;
        end
        if (got_r == n_r) begin
          neg_r <= sum_r[39];
          quo_r <= sum_r[39] ? 40'(-sum_r) : sum_r;
          rem_r <= '0;
          step_r <= '0;
        end
      end
      S_DIV: begin
        if (step_r == 7'd40) begin
          mean_r <= neg_r ? 33'(-quo_r) : quo_r[32:0];
          k_r <= '0; got_r <= '0; acc_r <= '0;
        end else begin
          step_r <= step_r + 1'b1;
          if (!dtry[40]) begin
            rem_r <= dtry[39:0];
            quo_r <= {quo_r[38:0], 1'b1};
          end else begin
            rem_r <= {rem_r[38:0], quo_r[39]};
            quo_r <= {quo_r[38:0], 1'b0};
          end
        end
      end
      S_DEV: begin
        if (issuing) k_r <= k_r + 1'b1;
        if (rd_pend_r) begin
          sq_r <= 64'(adif) * 64'(adif);
          got_r <= got_r + 1'b1;
        end
        if (got_r != '0 && (rd_pend_r || got_r == n_r))
          acc_r <= acc_r + 72'(sq_r);
      end
      S_MSQ: begin
        rem_r <= 40'(rem_r[15:0]) * 40'(rem_r[15:0]);
        a_r <= '0;
        step_r <= 7'd7;
      end
      S_MULN: begin
        if (step_r == 7'd0) begin
          a_r <= mul_nx - 80'(rem_r);
          root_r <= '0; rsq_r <= '0; step_r <= 7'd39;
        end else begin
          a_r <= mul_nx;
          step_r <= step_r - 1'b1;
        end
      end
      S_SQRT: begin
        root_r <= root_nx;
        if (csq <= a_r) rsq_r <= csq;
        if (step_r == 7'd0) begin
          quo_r <= root_nx; rem_r <= '0;
        end else step_r <= step_r - 1'b1;
      end
      S_DIVD: begin
        if (step_r == 7'd40) begin
          mean_o_r[crd_r] <= 32'(mean_r);
          dev_o_r[crd_r]  <= quo_r[31:0];
        end else begin
          step_r <= step_r + 1'b1;
          if (!dtry[40]) begin
            rem_r <= dtry[39:0];
            quo_r <= {quo_r[38:0], 1'b1};
          end else begin
            rem_r <= {rem_r[38:0], quo_r[39]};
            quo_r <= {quo_r[38:0], 1'b0};
          end
        end
      end
      S_NEXT: begin
        crd_r <= crd_r + 1'b1;
        k_r <= '0; got_r <= '0; sum_r <= '0;
      end
      S_OUT: ;
      default: ;
    endcase
  end
endmodule
